@@ hw/rtl/cpef_pkg.sv @@
// Package for the code point escape formatter.
// Holds the item descriptor, register indexes, character codes and the hex digit function.
package cpef_pkg;

	localparam int CPEF_QUEUE_DEPTH = 2;
	localparam int CP_W   = 32;
	localparam int CHAR_W = 7;
	localparam int NDIG_W = 4;
	localparam int POS_W  = 4;
	localparam int REG_W  = 2;

	typedef enum logic [REG_W-1:0] {
		REG_ESC_SQUOTE = 2'd0,
		REG_ESC_DQUOTE = 2'd1,
		REG_ESC_BSLASH = 2'd2,
		REG_UPPER_HEX  = 2'd3
	} reg_idx_t;

	localparam logic [CP_W-1:0] CP_SQUOTE  = 32'h0000_0027;
	localparam logic [CP_W-1:0] CP_DQUOTE  = 32'h0000_0022;
	localparam logic [CP_W-1:0] CP_BSLASH  = 32'h0000_005C;
	localparam logic [CP_W-1:0] CP_VIS_LO  = 32'h0000_0020;
	localparam logic [CP_W-1:0] CP_VIS_HI  = 32'h0000_007E;
	localparam logic [CP_W-1:0] CP_BYTE_MAX  = 32'h0000_00FF;
	localparam logic [CP_W-1:0] CP_PLANE0_MAX = 32'h0000_FFFF;
	localparam logic [CP_W-1:0] CP_UNI_MAX  = 32'h0010_FFFF;
	localparam logic [CP_W-1:0] CP_REPLACE  = 32'hFFFD_0000;

	localparam logic [3:0] CTL_NUL = 4'h0;
	localparam logic [3:0] CTL_BEL = 4'h7;
	localparam logic [3:0] CTL_BS  = 4'h8;
	localparam logic [3:0] CTL_TAB = 4'h9;
	localparam logic [3:0] CTL_LF  = 4'hA;
	localparam logic [3:0] CTL_VT  = 4'hB;
	localparam logic [3:0] CTL_FF  = 4'hC;
	localparam logic [3:0] CTL_CR  = 4'hD;

	localparam logic [CHAR_W-1:0] CH_BSLASH = 7'h5C;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
	localparam logic [CHAR_W-1:0] CH_LA     = 7'h61;
	localparam logic [CHAR_W-1:0] CH_UA     = 7'h41;
	localparam logic [CHAR_W-1:0] CH_LB     = 7'h62;
	localparam logic [CHAR_W-1:0] CH_LF     = 7'h66;
	localparam logic [CHAR_W-1:0] CH_LN     = 7'h6E;
	localparam logic [CHAR_W-1:0] CH_LR     = 7'h72;
	localparam logic [CHAR_W-1:0] CH_LT     = 7'h74;
	localparam logic [CHAR_W-1:0] CH_LV     = 7'h76;
	localparam logic [CHAR_W-1:0] CH_LX     = 7'h78;
	localparam logic [CHAR_W-1:0] CH_LU     = 7'h75;
	localparam logic [CHAR_W-1:0] CH_UU     = 7'h55;

	localparam logic [NDIG_W-1:0] NDIG_NONE = 4'd0;
	localparam logic [NDIG_W-1:0] NDIG_BYTE = 4'd2;
	localparam logic [NDIG_W-1:0] NDIG_BMP  = 4'd4;
	localparam logic [NDIG_W-1:0] NDIG_FULL = 4'd8;

	typedef struct packed {
		logic              esc_squote;
		logic              esc_dquote;
		logic              esc_bslash;
		logic              upper_hex;
	} cfg_t;

	typedef struct packed {
		logic              has_bs;
		logic              upper;
		logic [CHAR_W-1:0] ch;
		logic [NDIG_W-1:0] ndig;
		logic [CP_W-1:0]   digits;
	} desc_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [CHAR_W-1:0] base;
		base = upper ? CH_UA : CH_LA;
		if (nib < 4'd10)
			return CH_ZERO + {3'b000, nib};
		return base + {3'b000, nib} - 7'd10;
	endfunction

endpackage

@@ hw/rtl/cpef_front.sv @@
// Front end: configuration registers and classification of each accepted code point.
// Depends on cpef_pkg.
module cpef_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [cpef_pkg::CP_W-1:0]  code_point,
	input  logic                       cfg_we,
	input  logic [cpef_pkg::REG_W-1:0] cfg_index,
	input  logic                       cfg_wdata,
	output logic                       push,
	output cpef_pkg::desc_t            push_desc
);
	import cpef_pkg::*;

	cfg_t              cfg_q;
	logic              ctl_hit;
	logic [CHAR_W-1:0] ctl_ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ESC_SQUOTE: cfg_q.esc_squote <= cfg_wdata;
				REG_ESC_DQUOTE: cfg_q.esc_dquote <= cfg_wdata;
				REG_ESC_BSLASH: cfg_q.esc_bslash <= cfg_wdata;
				REG_UPPER_HEX:  cfg_q.upper_hex  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		ctl_hit = (code_point[CP_W-1:4] == '0);
		ctl_ch  = CH_ZERO;
		unique case (code_point[3:0])
			CTL_NUL: ctl_ch = CH_ZERO;
			CTL_BEL: ctl_ch = CH_LA;
			CTL_BS:  ctl_ch = CH_LB;
			CTL_FF:  ctl_ch = CH_LF;
			CTL_LF:  ctl_ch = CH_LN;
			CTL_CR:  ctl_ch = CH_LR;
			CTL_TAB: ctl_ch = CH_LT;
			CTL_VT:  ctl_ch = CH_LV;
			default: ctl_hit = 1'b0;
		endcase
	end

	always_comb begin
		push_desc        = '0;
		push_desc.upper  = cfg_q.upper_hex;
		push_desc.has_bs = 1'b1;
		push_desc.ndig   = NDIG_NONE;
		if (code_point == CP_SQUOTE) begin
			push_desc.has_bs = cfg_q.esc_squote;
			push_desc.ch     = code_point[CHAR_W-1:0];
		end else if (code_point == CP_DQUOTE) begin
			push_desc.has_bs = cfg_q.esc_dquote;
			push_desc.ch     = code_point[CHAR_W-1:0];
		end else if (code_point == CP_BSLASH) begin
			push_desc.has_bs = cfg_q.esc_bslash;
			push_desc.ch     = code_point[CHAR_W-1:0];
		end else if (ctl_hit) begin
			push_desc.ch     = ctl_ch;
		end else if (code_point >= CP_VIS_LO && code_point <= CP_VIS_HI) begin
			push_desc.has_bs = 1'b0;
			push_desc.ch     = code_point[CHAR_W-1:0];
		end else if (code_point <= CP_BYTE_MAX) begin
			push_desc.ch     = CH_LX;
			push_desc.ndig   = NDIG_BYTE;
			push_desc.digits = {code_point[7:0], 24'h0};
		end else if (code_point <= CP_PLANE0_MAX) begin
			push_desc.ch     = CH_LU;
			push_desc.ndig   = NDIG_BMP;
			push_desc.digits = {code_point[15:0], 16'h0};
		end else if (code_point <= CP_UNI_MAX) begin
			push_desc.ch     = CH_UU;
			push_desc.ndig   = NDIG_FULL;
			push_desc.digits = code_point;
		end else begin
			push_desc.ch     = CH_LU;
			push_desc.ndig   = NDIG_BMP;
			push_desc.digits = CP_REPLACE;
		end
	end

	assign push = accept;

endmodule

@@ hw/rtl/cpef_queue.sv @@
// Descriptor queue between the front end and the serializer.
// Depends on cpef_pkg.
module cpef_queue #(
	parameter int DEPTH = cpef_pkg::CPEF_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cpef_pkg::desc_t push_desc,
	input  logic            pop,
	output cpef_pkg::desc_t head,
	output logic            empty,
	output logic            full
);
	import cpef_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	desc_t             entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_FULL);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ hw/rtl/cpef_back.sv @@
// Serializer: walks one descriptor a byte per cycle into registered outputs.
// Depends on cpef_pkg.
module cpef_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  cpef_pkg::desc_t             head,
	output logic                        pop,
	output logic                        out_valid,
	output logic [cpef_pkg::CHAR_W-1:0] out_char,
	output logic                        last_char
);
	import cpef_pkg::*;

	desc_t             cur_q;
	logic              cur_valid_q;
	logic [POS_W-1:0]  pos_q;
	logic              is_last;
	logic [CHAR_W-1:0] byte_sel;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              last_q;

	assign is_last = (pos_q == cur_q.ndig + 1'b1);
	assign pop     = !q_empty && (!cur_valid_q || is_last);

	always_comb begin
		if (pos_q == '0)
			byte_sel = CH_BSLASH;
		else if (pos_q == POS_W'(1))
			byte_sel = cur_q.ch;
		else
			byte_sel = hex_char(cur_q.digits[CP_W-1 -: 4], cur_q.upper);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end else if (cur_valid_q && pos_q >= POS_W'(2)) begin
			cur_q.digits <= {cur_q.digits[CP_W-5:0], 4'h0};
		end
		out_char_q <= byte_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				pos_q       <= head.has_bs ? '0 : POS_W'(1);
			end else if (cur_valid_q) begin
				if (is_last)
					cur_valid_q <= 1'b0;
				pos_q <= pos_q + 1'b1;
			end
			out_valid_q <= cur_valid_q;
			last_q      <= cur_valid_q && is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_q;

endmodule

@@ hw/rtl/code_point_escape_formatter_top.sv @@
// Top level of the code point escape formatter.
// Instantiates cpef_front, cpef_queue and cpef_back; depends on cpef_pkg.
//
// Usage:
//   Command channel: drive code_point with start high; the item is taken at a rising
//   edge where start is high and busy is low. busy rises only while the descriptor
//   queue is full.
//   Result channel: out_valid strobes for one cycle per byte of escaped text, with
//   out_char holding the byte and last_char marking the final byte of the item.
//   Results cannot be held off; every strobe is a completed transfer.
//   Configuration: cfg_we writes bit cfg_wdata into register cfg_index at the edge
//   (0 escape single quote, 1 escape double quote, 2 escape backslash, 3 uppercase hex).
//   Write only while no item is in flight.
//   Path: an accepted item is classified, written to the descriptor queue, loaded by
//   the serializer once it is free, and each byte is registered onto out_char.
//   Throughput: one output byte per cycle, set by the serializer; an item is
//   1 to 10 bytes (1 for plain ASCII, 2 for simple escapes, 4, 6 or 10 for hex
//   escapes), and a queued next item follows the last byte without a gap.
//   Reset: arst_n clears the configuration registers to zero, empties the queue and drops out_valid.
module code_point_escape_formatter_top #(
	parameter int QUEUE_DEPTH = cpef_pkg::CPEF_QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [cpef_pkg::CP_W-1:0]   code_point,
	input  logic                        cfg_we,
	input  logic [cpef_pkg::REG_W-1:0]  cfg_index,
	input  logic                        cfg_wdata,
	output logic                        out_valid,
	output logic [cpef_pkg::CHAR_W-1:0] out_char,
	output logic                        last_char
);
	import cpef_pkg::*;

	logic  push;
	desc_t push_desc;
	logic  pop;
	desc_t head;
	logic  q_empty;
	logic  q_full;

	assign busy = q_full;

	cpef_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (start && !q_full),
		.code_point (code_point),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.push       (push),
		.push_desc  (push_desc)
	);

	cpef_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	cpef_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_char  (out_char),
		.last_char (last_char)
	);

endmodule

@@ hw/rtl/cpef_checker.sv @@
// Port-level checker for the code point escape formatter, bound to the top level.
// Depends on cpef_pkg.
module cpef_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        out_valid,
	input logic [cpef_pkg::CHAR_W-1:0] out_char,
	input logic                        last_char
);
	import cpef_pkg::*;

	a_last_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_char |-> out_valid)
		else $error("last_char without out_valid");

	a_bytes_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_char |=> out_valid)
		else $error("gap inside escaped text");

	a_busy_means_output: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> out_valid)
		else $error("queue full while serializer idle");

	a_accept_yields_output: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> ##2 out_valid)
		else $error("no output two cycles after a transfer");

	a_printable_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char >= CP_VIS_LO[CHAR_W-1:0] &&
		               out_char <= CP_VIS_HI[CHAR_W-1:0]))
		else $error("escaped text holds a non-printable byte");

endmodule

bind code_point_escape_formatter_top cpef_checker u_cpef_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.out_valid (out_valid),
	.out_char  (out_char),
	.last_char (last_char)
);

@@ tb/testbench.sv @@
// Testbench for code_point_escape_formatter_top: sends code points through the command port
// and checks every escaped byte against a predictor kept in step with the register writes.
// Depends on cpef_pkg and the formatter RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cpef_pkg::*;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_byte_t;

	localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
	localparam int          SEGMENT_ITEMS    = 50;
	localparam int          SEGMENTS         = 6;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                start      = 1'b0;
	logic [CP_W-1:0]     code_point = '0;
	logic                cfg_we     = 1'b0;
	logic [REG_W-1:0]    cfg_index  = '0;
	logic                cfg_wdata  = 1'b0;
	logic                busy;
	logic                out_valid;
	logic [CHAR_W-1:0]   out_char;
	logic                last_char;

	cfg_t                escape_cfg = '0;
	text_byte_t          pending_text[$];
	int                  mismatch_count = 0;

	code_point_escape_formatter_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.code_point (code_point),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (out_valid),
		.out_char   (out_char),
		.last_char  (last_char)
	);

	always #6 clk = ~clk;

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [CHAR_W-1:0] hex_glyph(input logic [3:0] nib);
		if (nib < 4'd10)
			return CH_ZERO + CHAR_W'(nib);
		return (escape_cfg.upper_hex ? CH_UA : CH_LA) + CHAR_W'(nib) - CHAR_W'(10);
	endfunction

	function automatic void predict_escape(input logic [CP_W-1:0] cp);
		logic [CHAR_W-1:0] txt[$];
		logic [CP_W-1:0]   hex_val;
		int                ndig;
		text_byte_t        tb_byte;
		ndig = 0;
		hex_val = cp;
		if (cp == CP_SQUOTE || cp == CP_DQUOTE || cp == CP_BSLASH) begin
			if ((cp == CP_SQUOTE && escape_cfg.esc_squote) ||
			    (cp == CP_DQUOTE && escape_cfg.esc_dquote) ||
			    (cp == CP_BSLASH && escape_cfg.esc_bslash))
				txt.push_back(CH_BSLASH);
			txt.push_back(cp[CHAR_W-1:0]);
		end else if (cp[CP_W-1:4] == '0 && (cp[3:0] == CTL_NUL || cp[3:0] == CTL_BEL ||
		           cp[3:0] == CTL_BS || cp[3:0] == CTL_FF || cp[3:0] == CTL_LF ||
		           cp[3:0] == CTL_CR || cp[3:0] == CTL_TAB || cp[3:0] == CTL_VT)) begin
			txt.push_back(CH_BSLASH);
			case (cp[3:0])
				CTL_NUL: txt.push_back(CH_ZERO);
				CTL_BEL: txt.push_back(CH_LA);
				CTL_BS:  txt.push_back(CH_LB);
				CTL_FF:  txt.push_back(CH_LF);
				CTL_LF:  txt.push_back(CH_LN);
				CTL_CR:  txt.push_back(CH_LR);
				CTL_TAB: txt.push_back(CH_LT);
				default: txt.push_back(CH_LV);
			endcase
		end else if (cp >= CP_VIS_LO && cp <= CP_VIS_HI) begin
			txt.push_back(cp[CHAR_W-1:0]);
		end else begin
			txt.push_back(CH_BSLASH);
			if (cp <= CP_BYTE_MAX) begin
				txt.push_back(CH_LX);
				ndig = 2;
			end else if (cp <= CP_PLANE0_MAX) begin
				txt.push_back(CH_LU);
				ndig = 4;
			end else if (cp <= CP_UNI_MAX) begin
				txt.push_back(CH_UU);
				ndig = 8;
			end else begin
				txt.push_back(CH_LU);
				ndig = 4;
				hex_val = CP_W'(REPLACEMENT_CHAR);
			end
			for (int i = ndig - 1; i >= 0; i--)
				txt.push_back(hex_glyph(hex_val[4*i +: 4]));
		end
		foreach (txt[i]) begin
			tb_byte.ch = txt[i];
			tb_byte.last = (i == txt.size() - 1);
			pending_text.push_back(tb_byte);
		end
	endfunction

	always @(posedge clk) begin
		text_byte_t want;
		if (arst_n && out_valid) begin
			if (pending_text.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected transfer, expected none, actual char %h last %b",
				         $time, out_char, last_char);
			end else begin
				want = pending_text.pop_front();
				if (out_char !== want.ch) begin
					mismatch_count++;
					$display("%0t: out_char mismatch, expected %h, actual %h",
					         $time, want.ch, out_char);
				end
				if (last_char !== want.last) begin
					mismatch_count++;
					$display("%0t: last_char mismatch, expected %b, actual %b",
					         $time, want.last, last_char);
				end
			end
		end
	end

	task automatic send_code(input logic [CP_W-1:0] cp);
		start <= 1'b1;
		code_point <= cp;
		do
			@(posedge clk);
		while (busy);
		predict_escape(cp);
	endtask

	task automatic idle_gap(input bit allow);
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (!allow || r < 55)
			len = 0;
		else if (r < 90)
			len = $urandom_range(1, 3);
		else
			len = $urandom_range(8, 30);
		if (len > 0) begin
			start <= 1'b0;
			code_point <= $urandom();
			repeat (len) @(posedge clk);
		end
	endtask

	task automatic put_reg(input reg_idx_t idx, input logic val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_ESC_SQUOTE: escape_cfg.esc_squote = val;
			REG_ESC_DQUOTE: escape_cfg.esc_dquote = val;
			REG_ESC_BSLASH: escape_cfg.esc_bslash = val;
			default:        escape_cfg.upper_hex  = val;
		endcase
	endtask

	task automatic set_config(input logic sq, input logic dq, input logic bs, input logic up);
		start <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		put_reg(REG_ESC_SQUOTE, sq);
		put_reg(REG_ESC_DQUOTE, dq);
		put_reg(REG_ESC_BSLASH, bs);
		put_reg(REG_UPPER_HEX, up);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CP_W-1:0] pick_code_point();
		case ($urandom_range(0, 9))
			0: case ($urandom_range(0, 2))
				0:       return CP_SQUOTE;
				1:       return CP_DQUOTE;
				default: return CP_BSLASH;
			endcase
			1: case ($urandom_range(0, 7))
				0:       return CP_W'(CTL_NUL);
				1:       return CP_W'(CTL_BEL);
				2:       return CP_W'(CTL_BS);
				3:       return CP_W'(CTL_FF);
				4:       return CP_W'(CTL_LF);
				5:       return CP_W'(CTL_CR);
				6:       return CP_W'(CTL_TAB);
				default: return CP_W'(CTL_VT);
			endcase
			2: return $urandom_range(CP_VIS_LO, CP_VIS_HI);
			3: return $urandom_range(0, CP_BYTE_MAX);
			4: return $urandom_range(CP_BYTE_MAX + 1, CP_PLANE0_MAX);
			5: return $urandom_range(CP_PLANE0_MAX + 1, CP_UNI_MAX);
			6: return $urandom_range(CP_UNI_MAX + 1, 32'hFFFF_FFFF);
			7: case ($urandom_range(0, 10))
				0:       return 32'h0000_001F;
				1:       return 32'h0000_0021;
				2:       return 32'h0000_007F;
				3:       return 32'h0000_0080;
				4:       return CP_BYTE_MAX;
				5:       return CP_BYTE_MAX + 1;
				6:       return CP_PLANE0_MAX;
				7:       return CP_PLANE0_MAX + 1;
				8:       return CP_UNI_MAX;
				9:       return CP_UNI_MAX + 1;
				default: return 32'hFFFF_FFFF;
			endcase
			default: return $urandom();
		endcase
	endfunction

	task automatic test_default_escapes();
		send_code(CP_SQUOTE);
		send_code(CP_DQUOTE);
		idle_gap(1'b1);
		send_code(CP_BSLASH);
		send_code(CP_W'(CTL_NUL));
		send_code(CP_W'(CTL_BEL));
		send_code(CP_W'(CTL_BS));
		idle_gap(1'b1);
		send_code(CP_W'(CTL_FF));
		send_code(CP_W'(CTL_LF));
		send_code(CP_W'(CTL_CR));
		send_code(CP_W'(CTL_TAB));
		send_code(CP_W'(CTL_VT));
		send_code(CP_VIS_LO);
		send_code(CP_VIS_HI);
	endtask

	task automatic test_hex_ranges();
		send_code(32'h0000_0001);
		send_code(32'h0000_007F);
		send_code(CP_BYTE_MAX);
		send_code(CP_BYTE_MAX + 1);
		send_code(CP_PLANE0_MAX);
		send_code(CP_UNI_MAX);
		send_code(CP_UNI_MAX + 1);
		send_code(32'hFFFF_FFFF);
	endtask

	task automatic test_escape_enables();
		set_config(1'b1, 1'b1, 1'b1, 1'b1);
		send_code(CP_SQUOTE);
		send_code(CP_DQUOTE);
		send_code(CP_BSLASH);
		send_code(32'h0000_00AB);
		send_code(CP_UNI_MAX);
		send_code(32'hFFFF_FFFF);
	endtask

	task automatic test_random_traffic();
		bit gaps;
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg == 0)
				set_config(1'b0, 1'b0, 1'b0, 1'b0);
			else if (seg == 1)
				set_config(1'b1, 1'b1, 1'b1, 1'b1);
			else
				set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			gaps = !(seg == 2 || seg == 5);
			for (int i = 0; i < SEGMENT_ITEMS; i++) begin
				send_code(pick_code_point());
				idle_gap(gaps);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_escapes();
		test_hex_ranges();
		test_escape_enables();
		test_random_traffic();
		start <= 1'b0;
		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ code_point_escape_formatter_top.f @@
hw/rtl/cpef_pkg.sv
hw/rtl/cpef_front.sv
hw/rtl/cpef_queue.sv
hw/rtl/cpef_back.sv
hw/rtl/code_point_escape_formatter_top.sv
hw/rtl/cpef_checker.sv
tb/testbench.sv
